### rtl/pipo_pkg.sv
// Shared constants, types and helper functions for the PIPO-64/128 encryption pipeline.
package pipo_pkg;

  localparam int unsigned BLOCK_W = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NBYTES  = BLOCK_W / BYTE_W;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_idx_e;

  // 8-bit S-box, applied to each bit column of the 8x8 bit matrix.
  localparam logic [7:0] SBOX [256] = '{
    8'h5E,8'hF9,8'hFC,8'h00,8'h3F,8'h85,8'hBA,8'h5B,8'h18,8'h37,8'hB2,8'hC6,8'h71,8'hC3,8'h74,8'h9D,
    8'hA7,8'h94,8'h0D,8'hE1,8'hCA,8'h68,8'h53,8'h2E,8'h49,8'h62,8'hEB,8'h97,8'hA4,8'h0E,8'h2D,8'hD0,
    8'h16,8'h25,8'hAC,8'h48,8'h63,8'hD1,8'hEA,8'h8F,8'hF7,8'h40,8'h45,8'hB1,8'h9E,8'h34,8'h1B,8'hF2,
    8'hB9,8'h86,8'h03,8'h7F,8'hD8,8'h7A,8'hDD,8'h3C,8'hE0,8'hCB,8'h52,8'h26,8'h15,8'hAF,8'h8C,8'h69,
    8'hC2,8'h75,8'h70,8'h1C,8'h33,8'h99,8'hB6,8'hC7,8'h04,8'h3B,8'hBE,8'h5A,8'hFD,8'h5F,8'hF8,8'h81,
    8'h93,8'hA0,8'h29,8'h4D,8'h66,8'hD4,8'hEF,8'h0A,8'hE5,8'hCE,8'h57,8'hA3,8'h90,8'h2A,8'h09,8'h6C,
    8'h22,8'h11,8'h88,8'hE4,8'hCF,8'h6D,8'h56,8'hAB,8'h7B,8'hDC,8'hD9,8'hBD,8'h82,8'h38,8'h07,8'h7E,
    8'hB5,8'h9A,8'h1F,8'hF3,8'h44,8'hF6,8'h41,8'h30,8'h4C,8'h67,8'hEE,8'h12,8'h21,8'h8B,8'hA8,8'hD5,
    8'h55,8'h6E,8'hE7,8'h0B,8'h28,8'h92,8'hA1,8'hCC,8'h2B,8'h08,8'h91,8'hED,8'hD6,8'h64,8'h4F,8'hA2,
    8'hBC,8'h83,8'h06,8'hFA,8'h5D,8'hFF,8'h58,8'h39,8'h72,8'hC5,8'hC0,8'hB4,8'h9B,8'h31,8'h1E,8'h77,
    8'h01,8'h3E,8'hBB,8'hDF,8'h78,8'hDA,8'h7D,8'h84,8'h50,8'h6B,8'hE2,8'h8E,8'hAD,8'h17,8'h24,8'hC9,
    8'hAE,8'h8D,8'h14,8'hE8,8'hD3,8'h61,8'h4A,8'h27,8'h47,8'hF0,8'hF5,8'h19,8'h36,8'h9C,8'hB3,8'h42,
    8'h1D,8'h32,8'hB7,8'h43,8'hF4,8'h46,8'hF1,8'h98,8'hEC,8'hD7,8'h4E,8'hAA,8'h89,8'h23,8'h10,8'h65,
    8'h8A,8'hA9,8'h20,8'h54,8'h6F,8'hCD,8'hE6,8'h13,8'hDB,8'h7C,8'h79,8'h05,8'h3A,8'h80,8'hBF,8'hDE,
    8'hE9,8'hD2,8'h4B,8'h2F,8'h0C,8'hA6,8'h95,8'h60,8'h0F,8'h2C,8'hA5,8'h51,8'h6A,8'hC8,8'hE3,8'h96,
    8'hB0,8'h9F,8'h1A,8'h76,8'hC1,8'h73,8'hC4,8'h35,8'hFE,8'h59,8'h5C,8'hB8,8'h87,8'h3D,8'h02,8'hFB
  };

  // Left rotation applied to each state byte after the S-box layer.
  localparam int unsigned ROT_AMT [NBYTES] = '{0, 7, 4, 3, 6, 5, 1, 2};

  // Rotate one byte left by a fixed amount.
  function automatic logic [BYTE_W-1:0] rotl8(logic [BYTE_W-1:0] b, int unsigned amt);
    logic [2*BYTE_W-1:0] w;
    w = {b, b} << amt;
    return w[2*BYTE_W-1:BYTE_W];
  endfunction

endpackage

### rtl/pipo_round_cell.sv
// One PIPO round as a registered cell of the round chain.
module pipo_round_cell
  import pipo_pkg::*;
#(
  parameter int unsigned RoundIdx = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [BLOCK_W-1:0] state_i,
  input  logic [BLOCK_W-1:0] rkey_i,
  output logic               valid_o,
  output logic [BLOCK_W-1:0] state_o
);

  localparam logic [BLOCK_W-1:0] RoundConst = BLOCK_W'(RoundIdx);

  logic [BLOCK_W-1:0] sb_out;
  logic [BLOCK_W-1:0] rot_out;
  logic [BLOCK_W-1:0] state_d, state_q;
  logic               valid_q;

  // S-box layer: column k gathers bit k of every byte, and its S-box output goes back in place.
  always_comb begin
    logic [BYTE_W-1:0] col;
    logic [BYTE_W-1:0] y;
    sb_out = '0;
    for (int k = 0; k < NBYTES; k++) begin
      for (int i = 0; i < BYTE_W; i++) begin
        col[i] = state_i[BYTE_W*i + k];
      end
      y = SBOX[col];
      for (int i = 0; i < BYTE_W; i++) begin
        sb_out[BYTE_W*i + k] = y[i];
      end
    end
  end

  // Byte rotations, then the round key with the round number mixed into its low bits.
  always_comb begin
    for (int k = 0; k < NBYTES; k++) begin
      rot_out[BYTE_W*k +: BYTE_W] = rotl8(sb_out[BYTE_W*k +: BYTE_W], ROT_AMT[k]);
    end
    state_d = rot_out ^ rkey_i ^ RoundConst;
  end

  // The valid flag is control state; the block value needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

### rtl/pipo64_128_encrypt.sv
// PIPO-64/128 encryption: key registers, initial key add and the chain of round cells.
// A block accepted at a clock edge leaves on ciphertext_o, with done_o high, once it has
// passed the chain of round cells (one registered cell per round).
// Throughput: one block per cycle; busy stays low, since every cell takes a new beat each cycle.
// Reset clears the key registers to zero and drops all in-flight beats.
// Results are shown for exactly one cycle; the receiver cannot stall them.
module pipo64_128_encrypt
  import pipo_pkg::*;
#(
  parameter int unsigned ROUNDS = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [BLOCK_W-1:0] plaintext_i,
  output logic               done_o,
  output logic [BLOCK_W-1:0] ciphertext_o,
  input  logic               cfg_we_i,
  input  cfg_idx_e           cfg_idx_i,
  input  logic [BLOCK_W-1:0] cfg_data_i
);

  logic [BLOCK_W-1:0] key_low_d, key_low_q;
  logic [BLOCK_W-1:0] key_high_d, key_high_q;

  logic [BLOCK_W-1:0] chain_state [ROUNDS+1];
  logic               chain_valid [ROUNDS+1];

  // Configuration write decode.
  always_comb begin
    key_low_d  = key_low_q;
    key_high_d = key_high_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_LOW:  key_low_d  = cfg_data_i;
        CFG_KEY_HIGH: key_high_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else begin
      key_low_q  <= key_low_d;
      key_high_q <= key_high_d;
    end
  end

  // The pipeline never stalls, so a new beat is taken on every start.
  assign busy = 1'b0;

  // Initial key add with round key zero feeds the first cell.
  assign chain_valid[0] = start && !busy;
  assign chain_state[0] = plaintext_i ^ key_low_q;

  // One cell per round; odd rounds use the high key half, even rounds the low half.
  for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
    pipo_round_cell #(
      .RoundIdx(r)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(chain_valid[r-1]),
      .state_i(chain_state[r-1]),
      .rkey_i ((r % 2 == 1) ? key_high_q : key_low_q),
      .valid_o(chain_valid[r]),
      .state_o(chain_state[r])
    );
  end

  assign done_o       = chain_valid[ROUNDS];
  assign ciphertext_o = chain_state[ROUNDS];

  // An accepted beat always comes out on done_o unless reset intervenes.
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##ROUNDS done_o)
    else $error("accepted block did not complete after ROUNDS cycles");

  // A result never appears without a matching accepted beat.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, ROUNDS))
    else $error("result strobe without an accepted block");

  // A write to the low key half lands in key_low_q.
  a_key_low_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_KEY_LOW) |=> key_low_q == $past(cfg_data_i))
    else $error("key_low write lost");

endmodule

### test/tb_pipo64_128_encrypt.sv
// Self-checking testbench for the PIPO-64/128 encryption pipeline.
`timescale 1ns / 100ps

module tb_pipo64_128_encrypt;
  import pipo_pkg::*;

  localparam int unsigned N_ROUNDS = 13;

  // Column S-box of the cipher, kept separate from the design's copy.
  localparam logic [7:0] COL_SBOX [256] = '{
    8'h5E,8'hF9,8'hFC,8'h00,8'h3F,8'h85,8'hBA,8'h5B,8'h18,8'h37,8'hB2,8'hC6,8'h71,8'hC3,8'h74,8'h9D,
    8'hA7,8'h94,8'h0D,8'hE1,8'hCA,8'h68,8'h53,8'h2E,8'h49,8'h62,8'hEB,8'h97,8'hA4,8'h0E,8'h2D,8'hD0,
    8'h16,8'h25,8'hAC,8'h48,8'h63,8'hD1,8'hEA,8'h8F,8'hF7,8'h40,8'h45,8'hB1,8'h9E,8'h34,8'h1B,8'hF2,
    8'hB9,8'h86,8'h03,8'h7F,8'hD8,8'h7A,8'hDD,8'h3C,8'hE0,8'hCB,8'h52,8'h26,8'h15,8'hAF,8'h8C,8'h69,
    8'hC2,8'h75,8'h70,8'h1C,8'h33,8'h99,8'hB6,8'hC7,8'h04,8'h3B,8'hBE,8'h5A,8'hFD,8'h5F,8'hF8,8'h81,
    8'h93,8'hA0,8'h29,8'h4D,8'h66,8'hD4,8'hEF,8'h0A,8'hE5,8'hCE,8'h57,8'hA3,8'h90,8'h2A,8'h09,8'h6C,
    8'h22,8'h11,8'h88,8'hE4,8'hCF,8'h6D,8'h56,8'hAB,8'h7B,8'hDC,8'hD9,8'hBD,8'h82,8'h38,8'h07,8'h7E,
    8'hB5,8'h9A,8'h1F,8'hF3,8'h44,8'hF6,8'h41,8'h30,8'h4C,8'h67,8'hEE,8'h12,8'h21,8'h8B,8'hA8,8'hD5,
    8'h55,8'h6E,8'hE7,8'h0B,8'h28,8'h92,8'hA1,8'hCC,8'h2B,8'h08,8'h91,8'hED,8'hD6,8'h64,8'h4F,8'hA2,
    8'hBC,8'h83,8'h06,8'hFA,8'h5D,8'hFF,8'h58,8'h39,8'h72,8'hC5,8'hC0,8'hB4,8'h9B,8'h31,8'h1E,8'h77,
    8'h01,8'h3E,8'hBB,8'hDF,8'h78,8'hDA,8'h7D,8'h84,8'h50,8'h6B,8'hE2,8'h8E,8'hAD,8'h17,8'h24,8'hC9,
    8'hAE,8'h8D,8'h14,8'hE8,8'hD3,8'h61,8'h4A,8'h27,8'h47,8'hF0,8'hF5,8'h19,8'h36,8'h9C,8'hB3,8'h42,
    8'h1D,8'h32,8'hB7,8'h43,8'hF4,8'h46,8'hF1,8'h98,8'hEC,8'hD7,8'h4E,8'hAA,8'h89,8'h23,8'h10,8'h65,
    8'h8A,8'hA9,8'h20,8'h54,8'h6F,8'hCD,8'hE6,8'h13,8'hDB,8'h7C,8'h79,8'h05,8'h3A,8'h80,8'hBF,8'hDE,
    8'hE9,8'hD2,8'h4B,8'h2F,8'h0C,8'hA6,8'h95,8'h60,8'h0F,8'h2C,8'hA5,8'h51,8'h6A,8'hC8,8'hE3,8'h96,
    8'hB0,8'h9F,8'h1A,8'h76,8'hC1,8'h73,8'hC4,8'h35,8'hFE,8'h59,8'h5C,8'hB8,8'h87,8'h3D,8'h02,8'hFB
  };

  // Left rotation of each state byte after the S-box layer.
  localparam int unsigned BYTE_ROT [8] = '{0, 7, 4, 3, 6, 5, 1, 2};

  // Holds the key copy, computes ciphertexts and compares them in order.
  class cipher_scoreboard;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [63:0] pending_ct [$];
    int unsigned errors;

    function new();
      key_lo = '0;
      key_hi = '0;
      errors = 0;
    endfunction

    function void set_key(cfg_idx_e idx, logic [63:0] value);
      case (idx)
        CFG_KEY_LOW:  key_lo = value;
        CFG_KEY_HIGH: key_hi = value;
        default: ;
      endcase
    endfunction

    // Bit 8k+i of the result is bit 8i+k of the input.
    function logic [63:0] transpose(logic [63:0] x);
      logic [63:0] y;
      y = '0;
      for (int k = 0; k < 8; k++) begin
        for (int i = 0; i < 8; i++) begin
          y[8*k+i] = x[8*i+k];
        end
      end
      return y;
    endfunction

    function logic [63:0] encrypt(logic [63:0] pt);
      logic [63:0] s;
      logic [63:0] t;
      logic [63:0] u;
      logic [7:0]  b;
      s = pt ^ key_lo;
      for (int unsigned r = 1; r <= N_ROUNDS; r++) begin
        t = transpose(s);
        for (int k = 0; k < 8; k++) begin
          u[8*k +: 8] = COL_SBOX[t[8*k +: 8]];
        end
        s = transpose(u);
        for (int k = 0; k < 8; k++) begin
          b = s[8*k +: 8];
          b = (b << BYTE_ROT[k]) | (b >> (8 - BYTE_ROT[k]));
          u[8*k +: 8] = b;
        end
        s = u ^ ((r % 2 == 1) ? key_hi : key_lo) ^ 64'(r);
      end
      return s;
    endfunction

    function void note_block(logic [63:0] pt);
      pending_ct.push_back(encrypt(pt));
    endfunction

    function void check_block(logic [63:0] ct);
      logic [63:0] want;
      if (pending_ct.size() == 0) begin
        errors++;
        $display("%0t: unexpected ciphertext, expected none, actual %h", $time, ct);
      end else begin
        want = pending_ct.pop_front();
        if (ct !== want) begin
          errors++;
          $display("%0t: ciphertext mismatch, expected %h, actual %h", $time, want, ct);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] plaintext_i;
  logic        done_o;
  logic [63:0] ciphertext_o;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [63:0] cfg_data_i;

  cipher_scoreboard sb;

  pipo64_128_encrypt #(
    .ROUNDS(N_ROUNDS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .plaintext_i (plaintext_i),
    .done_o      (done_o),
    .ciphertext_o(ciphertext_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Record accepted blocks and check every ciphertext beat.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (start && busy === 1'b0) sb.note_block(plaintext_i);
      if (done_o !== 1'b0) sb.check_block(ciphertext_o);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly no gap, some short gaps and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Plaintexts: mostly random, with sparse and dense patterns mixed in.
  function automatic logic [63:0] pick_plaintext();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 64'd1 << $urandom_range(0, 63);
    if (r == 1) return ~(64'd1 << $urandom_range(0, 63));
    if (r == 2) return '0;
    if (r == 3) return '1;
    return rand64();
  endfunction

  function automatic logic [63:0] pick_key_half();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return rand64();
  endfunction

  // Present one block, after an optional gap, and hold it until it is taken.
  task automatic send_block(logic [63:0] pt, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      plaintext_i <= rand64();
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    plaintext_i <= pt;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // Stop sending and let the pipeline drain completely.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_ct.size() != 0) @(posedge clk_i);
    repeat (N_ROUNDS + 2) @(posedge clk_i);
  endtask

  // Write both key halves while the pipeline is empty.
  task automatic load_key(logic [63:0] lo, logic [63:0] hi);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_KEY_LOW;
    cfg_data_i <= lo;
    @(posedge clk_i);
    sb.set_key(CFG_KEY_LOW, lo);
    cfg_idx_i <= CFG_KEY_HIGH;
    cfg_data_i <= hi;
    @(posedge clk_i);
    sb.set_key(CFG_KEY_HIGH, hi);
    cfg_we_i <= 1'b0;
    cfg_data_i <= rand64();
    @(posedge clk_i);
  endtask

  // Stimulus: directed patterns under extreme keys, then random phases.
  initial begin
    logic [63:0] corner_pt [6];
    logic [63:0] corner_key [4][2];
    bit          burst;

    corner_pt = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'h1, 64'h8000_0000_0000_0000};
    corner_key = '{'{64'h0, 64'h0}, '{'1, '1}, '{64'h0, '1}, '{'1, 64'h0}};

    sb = new();
    start = 1'b0;
    plaintext_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_KEY_LOW;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first set runs on the key left by reset.
    for (int c = 0; c < 4; c++) begin
      if (c > 0) load_key(corner_key[c][0], corner_key[c][1]);
      for (int i = 0; i < 6; i++) begin
        send_block(corner_pt[i], (c == 3) ? pick_gap() : 0);
      end
    end

    // Random phases, each under a new key; some run without gaps.
    for (int p = 0; p < 7; p++) begin
      load_key(pick_key_half(), pick_key_half());
      burst = (p % 3 == 2);
      for (int n = 0; n < 250; n++) begin
        send_block(pick_plaintext(), burst ? 0 : pick_gap());
      end
    end

    drain();
    repeat (N_ROUNDS + 5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_ct.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
rtl/pipo_pkg.sv
rtl/pipo_round_cell.sv
rtl/pipo64_128_encrypt.sv
test/tb_pipo64_128_encrypt.sv
